// File: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
// SPDS_ASSERT expects clk_i and rst_ni, SPDS_ASSERT_ALWAYS only clk_i, in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising clock edge outside reset
`define SPDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define SPDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SPDS_ASSERT(lbl, prop, msg)
`define SPDS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/spds_pkg.sv
`default_nettype none

package spds_pkg;

  // angles in unsigned q8.8 degrees
  localparam logic [15:0] FULL_ANGLE = 16'd46080;
  localparam logic [15:0] MID_ANGLE  = 16'd23040;

  // configuration register file
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW      = 8'd2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [15:0] RST_MIN_PULSE = 16'd1000;
  localparam logic [15:0] RST_MAX_PULSE = 16'd2000;
  localparam logic [23:0] RST_SLEW      = 24'd5033;

  // quotient bits of the width-to-angle division
  localparam int unsigned DIV_STEPS = 16;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [23:0] slew;
  } spds_cfg_t;

  // what the front end found in one tick
  typedef struct packed {
    logic power;
    logic pulse_end;
    logic strobe;
    logic measuring;
  } spds_flags_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAP,
    BK_DIV,
    BK_SLEW,
    BK_OUT
  } spds_bk_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/spds_if.sv
`default_nettype none

// tick channel
interface spds_in_if;
  logic valid;
  logic ready;
  logic power_ok;
  logic sig_level;
  logic update_strobe;

  modport source (output valid, output power_ok, output sig_level, output update_strobe,
                  input ready);
  modport sink (input valid, input power_ok, input sig_level, input update_strobe,
                output ready);
endinterface

// result channel
interface spds_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [15:0] target;
  logic        pulse_active;

  modport source (output valid, output position, output target, output pulse_active,
                  input ready);
  modport sink (input valid, input position, input target, input pulse_active,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/servo_pulse_decoder_slew_unit.sv
// channel   dir  payload                                 handshake
// in_ch     in   power_ok, sig_level, update_strobe      valid / ready
// out_ch    out  position, target, pulse_active (q8.8)   valid / ready
// cfg       in   cfg_idx_i, cfg_data_i                   cfg_we_i, no wait
//
// a tick passes the back end states map, slew and present, with a division
// between map and slew when a pulse ends strictly inside the window: the
// width-to-angle division retires one quotient bit per cycle
// the front end accepts a tick per cycle while the two-entry queue has room
// a result waits in the output register until taken; the queue keeps filling
// reset puts both angles at 90 degrees and clears the counters, no clearing pass
`default_nettype none

module servo_pulse_decoder_slew_unit
  import spds_pkg::*;
#(
  parameter int unsigned WIDTH_BITS   = 16,
  parameter int unsigned ELAPSED_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  spds_in_if.sink                   in_ch,
  spds_out_if.source                out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned QW = $bits(spds_flags_t) + WIDTH_BITS + ELAPSED_BITS;

  spds_cfg_t               cfg_q, cfg_d;
  spds_flags_t             f_flags, b_flags;
  logic [WIDTH_BITS-1:0]   f_width, b_width;
  logic [ELAPSED_BITS-1:0] f_elapsed, b_elapsed;
  logic                    push, pop, full, empty;
  logic [QW-1:0]           q_rdata;

  // register file, min kept below max
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_PULSE: begin
          if (cfg_data_i[15:0] < cfg_q.max_pulse) cfg_d.min_pulse = cfg_data_i[15:0];
        end
        REG_MAX_PULSE: begin
          if (cfg_data_i[15:0] > cfg_q.min_pulse) cfg_d.max_pulse = cfg_data_i[15:0];
        end
        REG_SLEW: begin
          cfg_d.slew = cfg_data_i[23:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse <= RST_MIN_PULSE;
      cfg_q.max_pulse <= RST_MAX_PULSE;
      cfg_q.slew      <= RST_SLEW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end
  spds_front #(
    .WIDTH_BITS   (WIDTH_BITS),
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_o      (in_ch.ready),
    .power_ok_i      (in_ch.power_ok),
    .sig_level_i     (in_ch.sig_level),
    .update_strobe_i (in_ch.update_strobe),
    .full_i          (full),
    .push_o          (push),
    .flags_o         (f_flags),
    .width_o         (f_width),
    .elapsed_o       (f_elapsed)
  );

  // queue between the halves
  spds_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_flags, f_width, f_elapsed}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_flags, b_width, b_elapsed} = q_rdata;

  // back end
  spds_back #(
    .WIDTH_BITS   (WIDTH_BITS),
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (empty),
    .flags_i        (b_flags),
    .width_i        (b_width),
    .elapsed_i      (b_elapsed),
    .pop_o          (pop),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .position_o     (out_ch.position),
    .target_o       (out_ch.target),
    .pulse_active_o (out_ch.pulse_active)
  );

endmodule

`default_nettype wire

// File: hw/rtl/spds_fifo.sv
`default_nettype none

module spds_fifo #(
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          pop_i,
  output logic     [DW-1:0]  rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned DEPTH = 2;

  logic [DW-1:0] mem_q [DEPTH];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign full_o  = (count_q == 2'(DEPTH));
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spds_front.sv
`default_nettype none

module spds_front
  import spds_pkg::*;
#(
  parameter int unsigned WIDTH_BITS   = 16,
  parameter int unsigned ELAPSED_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    power_ok_i,
  input  wire logic                    sig_level_i,
  input  wire logic                    update_strobe_i,
  input  wire logic                    full_i,
  output logic                         push_o,
  output spds_flags_t                  flags_o,
  output logic [WIDTH_BITS-1:0]        width_o,
  output logic [ELAPSED_BITS-1:0]      elapsed_o
);

  logic                    prev_sig_q, prev_sig_d;
  logic                    meas_q, meas_d;
  logic [WIDTH_BITS-1:0]   count_q, count_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
  logic [ELAPSED_BITS-1:0] elapsed_inc;
  logic [WIDTH_BITS-1:0]   count_inc;
  logic                    rising, falling;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign rising      = sig_level_i && !prev_sig_q;
  assign falling     = !sig_level_i && prev_sig_q;
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + ELAPSED_BITS'(1);
  assign count_inc   = (&count_q) ? count_q : count_q + WIDTH_BITS'(1);

  // per-tick edge detection and pulse measurement
  always_comb begin
    prev_sig_d = prev_sig_q;
    meas_d     = meas_q;
    count_d    = count_q;
    elapsed_d  = elapsed_q;
    flags_o    = '0;
    width_o    = count_inc;
    elapsed_o  = elapsed_inc;
    flags_o.power  = power_ok_i;
    flags_o.strobe = update_strobe_i;
    if (push_o) begin
      prev_sig_d = sig_level_i;
      elapsed_d  = update_strobe_i ? '0 : elapsed_inc;
      if (!power_ok_i) begin
        meas_d  = 1'b0;
        count_d = '0;
      end else if (rising) begin
        meas_d  = 1'b1;
        count_d = '0;
      end else if (meas_q) begin
        count_d = count_inc;
        if (falling) begin
          meas_d            = 1'b0;
          flags_o.pulse_end = 1'b1;
        end
      end
    end
    flags_o.measuring = meas_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sig_q <= 1'b0;
      meas_q     <= 1'b0;
      count_q    <= '0;
      elapsed_q  <= '0;
    end else begin
      prev_sig_q <= prev_sig_d;
      meas_q     <= meas_d;
      count_q    <= count_d;
      elapsed_q  <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spds_back.sv
`default_nettype none
`include "assert_macros.svh"

module spds_back
  import spds_pkg::*;
#(
  parameter int unsigned WIDTH_BITS   = 16,
  parameter int unsigned ELAPSED_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire spds_cfg_t               cfg_i,
  input  wire logic                    empty_i,
  input  wire spds_flags_t             flags_i,
  input  wire logic [WIDTH_BITS-1:0]   width_i,
  input  wire logic [ELAPSED_BITS-1:0] elapsed_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [15:0]                  position_o,
  output logic [15:0]                  target_o,
  output logic                         pulse_active_o
);

  localparam int unsigned CW = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;
  localparam int unsigned PW = ELAPSED_BITS + 8;
  localparam int unsigned SW = $clog2(DIV_STEPS);

  spds_bk_state_e state_q, state_d;

  spds_flags_t             flags_q, flags_d;
  logic [WIDTH_BITS-1:0]   width_q, width_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
  logic [15:0]             shaft_q, shaft_d;
  logic [15:0]             target_q, target_d;
  logic [PW-1:0]           reach_q, reach_d;
  logic [15:0]             rem_q, rem_d;
  logic [15:0]             num_q, num_d;
  logic [SW-1:0]           step_q, step_d;

  logic [CW-1:0]           w_ext, min_ext, max_ext;
  logic [15:0]             diff;
  logic [31:0]             numer;
  logic [15:0]             divisor;
  logic [17:0]             trial;
  logic                    qbit;
  logic [ELAPSED_BITS+23:0] prod;
  logic [15:0]             gap_abs;

  assign w_ext   = CW'(width_q);
  assign min_ext = CW'(cfg_i.min_pulse);
  assign max_ext = CW'(cfg_i.max_pulse);
  assign diff    = 16'(w_ext - min_ext);
  assign numer   = {16'd0, diff} * {16'd0, FULL_ANGLE};
  assign divisor = cfg_i.max_pulse - cfg_i.min_pulse;

  // one restoring division step
  assign trial = {1'b0, rem_q, num_q[15]} - {2'b00, divisor};
  assign qbit  = !trial[17];

  // reach in q8.8 degrees
  assign prod = {{24{1'b0}}, elapsed_q} * {{ELAPSED_BITS{1'b0}}, cfg_i.slew};

  assign gap_abs = (target_q > shaft_q) ? target_q - shaft_q : shaft_q - target_q;

  assign out_valid_o    = (state_q == BK_OUT);
  assign position_o     = shaft_q;
  assign target_o       = target_q;
  assign pulse_active_o = flags_q.measuring;

  // sequencer: map, divide, slew, present
  always_comb begin
    state_d   = state_q;
    flags_d   = flags_q;
    width_d   = width_q;
    elapsed_d = elapsed_q;
    shaft_d   = shaft_q;
    target_d  = target_q;
    reach_d   = reach_q;
    rem_d     = rem_q;
    num_d     = num_q;
    step_d    = step_q;
    pop_o     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          flags_d   = flags_i;
          width_d   = width_i;
          elapsed_d = elapsed_i;
          state_d   = BK_MAP;
        end
      end
      BK_MAP: begin
        reach_d = PW'(prod >> 16);
        state_d = BK_SLEW;
        if (!flags_q.power) begin
          target_d = MID_ANGLE;
        end else if (flags_q.pulse_end) begin
          if (w_ext <= min_ext) begin
            target_d = 16'd0;
          end else if (w_ext >= max_ext) begin
            target_d = FULL_ANGLE;
          end else begin
            rem_d   = numer[31:16];
            num_d   = numer[15:0];
            step_d  = '0;
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        rem_d  = qbit ? trial[15:0] : {rem_q[14:0], num_q[15]};
        num_d  = {num_q[14:0], qbit};
        step_d = step_q + SW'(1);
        if (step_q == SW'(DIV_STEPS - 1)) begin
          target_d = {num_q[14:0], qbit};
          state_d  = BK_SLEW;
        end
      end
      BK_SLEW: begin
        if (flags_q.strobe) begin
          if (PW'(gap_abs) > reach_q) begin
            shaft_d = (target_q > shaft_q) ? shaft_q + reach_q[15:0]
                                           : shaft_q - reach_q[15:0];
          end else begin
            shaft_d = target_q;
          end
        end
        state_d = BK_OUT;
      end
      BK_OUT: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      shaft_q  <= MID_ANGLE;
      target_q <= MID_ANGLE;
      flags_q  <= '0;
    end else begin
      state_q  <= state_d;
      shaft_q  <= shaft_d;
      target_q <= target_d;
      flags_q  <= flags_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    width_q   <= width_d;
    elapsed_q <= elapsed_d;
    reach_q   <= reach_d;
    rem_q     <= rem_d;
    num_q     <= num_d;
    step_q    <= step_d;
  end

  `SPDS_ASSERT(a_out_holds, (state_q == BK_OUT && !out_ready_i) |=> (state_q == BK_OUT), "result dropped before taken")
  `SPDS_ASSERT(a_angle_range, (shaft_q <= FULL_ANGLE) && (target_q <= FULL_ANGLE), "angle beyond 180 degrees")
  `SPDS_ASSERT(a_div_rem, (state_q == BK_DIV) |-> (rem_q < divisor), "division remainder not below divisor")

endmodule

`default_nettype wire
